// ----- sv/spq_pkg.sv -----
// Shared types and codes for the sorted priority queue.
package spq_pkg;

    // Fixed widths of the request and response words
    localparam int REQ_W     = 2;
    localparam int ID_W      = 16;
    localparam int PRIO_W    = 16;
    localparam int STAT_W    = 3;
    localparam int CNT_OUT_W = 7;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_INSERT  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_POP     = 2'd1;
    localparam logic [REQ_W-1:0] REQ_UPGRADE = 2'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR   = 2'd3;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOTFOUND  = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOTURGENT = 3'd4;

    typedef struct packed {
        logic [REQ_W-1:0]         req_type;
        logic [ID_W-1:0]          patient_id;
        logic signed [PRIO_W-1:0] prio_value;
    } spq_req_t;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic [ID_W-1:0]          popped_id;
        logic signed [PRIO_W-1:0] popped_prio;
        logic [ID_W-1:0]          front_id;
        logic signed [PRIO_W-1:0] front_prio;
        logic                     queue_empty;
        logic [CNT_OUT_W-1:0]     entry_count;
    } spq_rsp_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_MOVE
    } spq_state_t;

    // Controller to datapath
    typedef struct packed {
        logic latch;   // capture the incoming request word
        logic find;    // register the upgrade search results
        logic apply;   // update the cells and load the response register
    } spq_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_upgrade;
        logic out_free;
    } spq_stat_t;

endpackage

// ----- sv/spq_stream_if.sv -----
// Valid/ready channel carrying one word of a given payload type.
interface spq_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
    modport monitor (input valid, input ready, input payload);
endinterface

// ----- sv/spq_ctrl.sv -----
// Request sequencer for the sorted priority queue.
module spq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  spq_pkg::spq_stat_t  stat,
    output spq_pkg::spq_cmd_t   cmd
);

    spq_pkg::spq_state_t state_reg;
    spq_pkg::spq_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            spq_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = spq_pkg::S_EXEC;
                end
            end
            spq_pkg::S_EXEC:
            begin
                if (stat.is_upgrade)
                begin
                    state_next = spq_pkg::S_MOVE;
                end
                else if (stat.out_free)
                begin
                    state_next = spq_pkg::S_IDLE;
                end
            end
            spq_pkg::S_MOVE:
            begin
                if (stat.out_free)
                begin
                    state_next = spq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = spq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready = 1'b0;
        cmd       = '0;
        unique case (state_reg)
            spq_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                cmd.latch = req_valid;
            end
            spq_pkg::S_EXEC:
            begin
                cmd.find  = stat.is_upgrade;
                cmd.apply = !stat.is_upgrade && stat.out_free;
            end
            spq_pkg::S_MOVE:
            begin
                cmd.apply = stat.out_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- sv/spq_datapath.sv -----
// Row of sorted cells with per-cell compare, shift logic and response register.
module spq_datapath #(
    parameter int QUEUE_DEPTH = 64,
    parameter int ID_BITS     = 16,
    parameter int PRIO_BITS   = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  spq_pkg::spq_cmd_t  cmd,
    output spq_pkg::spq_stat_t stat,
    input  spq_pkg::spq_req_t  req_payload,
    input  logic               rsp_ready,
    output logic               rsp_valid,
    output spq_pkg::spq_rsp_t  rsp_payload
);

    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int LOG_D     = $clog2(QUEUE_DEPTH);
    localparam int OUT_ID_W  = spq_pkg::ID_W;
    localparam int OUT_PR_W  = spq_pkg::PRIO_W;
    localparam int OUT_CNT_W = spq_pkg::CNT_OUT_W;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    // Cells
    logic [ID_BITS-1:0]          ids_reg    [QUEUE_DEPTH];
    logic signed [PRIO_BITS-1:0] prios_reg  [QUEUE_DEPTH];
    logic [ID_BITS-1:0]          ids_next   [QUEUE_DEPTH];
    logic signed [PRIO_BITS-1:0] prios_next [QUEUE_DEPTH];
    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            count_next;

    // Captured request
    logic [spq_pkg::REQ_W-1:0]   op_reg;
    logic [ID_BITS-1:0]          id_reg;
    logic signed [PRIO_BITS-1:0] pr_reg;

    // Upgrade search results
    logic [QUEUE_DEPTH-1:0]      pfx_reg;
    logic                        found_reg;
    logic                        late_reg;

    // Response
    spq_pkg::spq_rsp_t           rsp_reg;
    logic                        rsp_valid_reg;

    // Per-cell flags
    logic [QUEUE_DEPTH-1:0]      valid_c;
    logic [QUEUE_DEPTH-1:0]      le_c;
    logic [QUEUE_DEPTH-1:0]      lt_c;
    logic [QUEUE_DEPTH-1:0]      match_c;
    logic [QUEUE_DEPTH-1:0]      incl_c;
    logic [QUEUE_DEPTH-1:0]      first_c;
    logic [QUEUE_DEPTH-1:0]      keep_c;

    logic [spq_pkg::STAT_W-1:0]  st;
    logic                        do_write;
    logic [ID_BITS-1:0]          front_id_src;
    logic signed [PRIO_BITS-1:0] front_pr_src;

    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            valid_c[i] = CNT_W'(i) < count_reg;
            le_c[i]    = prios_reg[i] <= pr_reg;
            lt_c[i]    = prios_reg[i] < pr_reg;
            match_c[i] = valid_c[i] && (ids_reg[i] == id_reg);
        end
        // Log-depth prefix OR: bit i set when some cell at or below i matches
        incl_c = match_c;
        for (int k = 0; k < LOG_D; k++)
        begin
            incl_c = incl_c | (incl_c << (1 << k));
        end
        first_c = match_c & ~(incl_c << 1);
    end

    // Cells that hold their entry; the rest take the new entry or shift back by one
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (op_reg == spq_pkg::REQ_INSERT)
            begin
                keep_c[i] = valid_c[i] && le_c[i];
            end
            else
            begin
                keep_c[i] = pfx_reg[i] || le_c[i];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            ids_next[i]   = ids_reg[i];
            prios_next[i] = prios_reg[i];
        end
        unique case (op_reg)
            spq_pkg::REQ_INSERT, spq_pkg::REQ_UPGRADE:
            begin
                if (!keep_c[0])
                begin
                    ids_next[0]   = id_reg;
                    prios_next[0] = pr_reg;
                end
                for (int i = 1; i < QUEUE_DEPTH; i++)
                begin
                    if (!keep_c[i])
                    begin
                        if (keep_c[i-1])
                        begin
                            ids_next[i]   = id_reg;
                            prios_next[i] = pr_reg;
                        end
                        else
                        begin
                            ids_next[i]   = ids_reg[i-1];
                            prios_next[i] = prios_reg[i-1];
                        end
                    end
                end
            end
            spq_pkg::REQ_POP:
            begin
                for (int i = 0; i < QUEUE_DEPTH - 1; i++)
                begin
                    ids_next[i]   = ids_reg[i+1];
                    prios_next[i] = prios_reg[i+1];
                end
            end
            spq_pkg::REQ_CLEAR:
            begin
                ids_next[0] = ids_reg[0];
            end
            default:
            begin
                ids_next[0] = ids_reg[0];
            end
        endcase
    end

    always_comb
    begin
        st         = spq_pkg::ST_OK;
        count_next = count_reg;
        unique case (op_reg)
            spq_pkg::REQ_INSERT:
            begin
                if (count_reg == FULL_CNT)
                begin
                    st = spq_pkg::ST_FULL;
                end
            end
            spq_pkg::REQ_POP:
            begin
                if (count_reg == '0)
                begin
                    st = spq_pkg::ST_EMPTY;
                end
            end
            spq_pkg::REQ_UPGRADE:
            begin
                priority if (!found_reg)
                begin
                    st = spq_pkg::ST_NOTFOUND;
                end
                else if (late_reg)
                begin
                    st = spq_pkg::ST_NOTURGENT;
                end
            end
            spq_pkg::REQ_CLEAR:
            begin
                st = spq_pkg::ST_OK;
            end
            default:
            begin
                st = spq_pkg::ST_OK;
            end
        endcase

        do_write = cmd.apply && (st == spq_pkg::ST_OK);

        if (do_write)
        begin
            unique case (op_reg)
                spq_pkg::REQ_INSERT:  count_next = count_reg + CNT_W'(1);
                spq_pkg::REQ_POP:     count_next = count_reg - CNT_W'(1);
                spq_pkg::REQ_CLEAR:   count_next = '0;
                spq_pkg::REQ_UPGRADE: count_next = count_reg;
                default:              count_next = count_reg;
            endcase
        end

        front_id_src = do_write ? ids_next[0] : ids_reg[0];
        front_pr_src = do_write ? prios_next[0] : prios_reg[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.apply)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            for (int i = 0; i < QUEUE_DEPTH; i++)
            begin
                ids_reg[i]   <= ids_next[i];
                prios_reg[i] <= prios_next[i];
            end
        end
        if (cmd.latch)
        begin
            op_reg <= req_payload.req_type;
            id_reg <= ID_BITS'(req_payload.patient_id);
            pr_reg <= PRIO_BITS'(req_payload.prio_value);
        end
        if (cmd.find)
        begin
            pfx_reg   <= incl_c << 1;
            found_reg <= |match_c;
            late_reg  <= |(first_c & lt_c);
        end
        if (cmd.apply)
        begin
            rsp_reg.status <= st;
            if (do_write && (op_reg == spq_pkg::REQ_POP))
            begin
                rsp_reg.popped_id   <= OUT_ID_W'(ids_reg[0]);
                rsp_reg.popped_prio <= OUT_PR_W'(prios_reg[0]);
            end
            else
            begin
                rsp_reg.popped_id   <= '0;
                rsp_reg.popped_prio <= '0;
            end
            if (count_next != '0)
            begin
                rsp_reg.front_id   <= OUT_ID_W'(front_id_src);
                rsp_reg.front_prio <= OUT_PR_W'(front_pr_src);
            end
            else
            begin
                rsp_reg.front_id   <= '0;
                rsp_reg.front_prio <= '0;
            end
            rsp_reg.queue_empty <= (count_next == '0);
            rsp_reg.entry_count <= OUT_CNT_W'(count_next);
        end
    end

    assign stat.is_upgrade = (op_reg == spq_pkg::REQ_UPGRADE);
    assign stat.out_free   = !rsp_valid_reg || rsp_ready;
    assign rsp_valid       = rsp_valid_reg;
    assign rsp_payload     = rsp_reg;

endmodule

// ----- sv/sorted_priority_queue_with_upgrade_core.sv -----
// Sorted priority queue with upgrade: top level joining sequencer and cell row.
// Holds up to QUEUE_DEPTH (id, priority) entries in a row of registered cells,
// kept sorted with the smallest priority at the front and ties in arrival
// order. One request word is handled at a time, and each produces exactly one
// response word. A word is captured in the idle state. For insert, pop and
// clear, every cell compares against it and shifts in place in the execute
// state. Upgrade instead registers the search for the front-most matching id
// there and shifts in the move state. A response that is not taken holds
// the block in its final state until the response register frees. The cells
// have no reset and need no clearing pass; only the entry count and the
// response valid flag are cleared.
module sorted_priority_queue_with_upgrade_core #(
    parameter int QUEUE_DEPTH = 64,
    parameter int ID_BITS     = 16,
    parameter int PRIO_BITS   = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    spq_stream_if.sink    req,
    spq_stream_if.source  rsp
);

    spq_pkg::spq_cmd_t  cmd;
    spq_pkg::spq_stat_t stat;
    spq_pkg::spq_req_t  req_word;
    spq_pkg::spq_rsp_t  rsp_word;
    logic               req_ready;
    logic               rsp_valid;

    assign req_word    = req.payload;
    assign req.ready   = req_ready;
    assign rsp.valid   = rsp_valid;
    assign rsp.payload = rsp_word;

    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    spq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS),
        .PRIO_BITS   (PRIO_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .req_payload (req_word),
        .rsp_ready   (rsp.ready),
        .rsp_valid   (rsp_valid),
        .rsp_payload (rsp_word)
    );

endmodule

// ----- sv/spq_checker.sv -----
// Port-level checks for the sorted priority queue, bound to the top level.
module spq_port_checks (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input spq_pkg::spq_req_t  req_word,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input spq_pkg::spq_rsp_t  rsp_word
);

    // One request word in flight at a time
    a_one_in_flight: assert property (
        @(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready
    ) else $error("request accepted while previous word still in flight");

    // Response timing for a non-upgrade word accepted while the response side is ready
    a_latency: assert property (
        @(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && rsp_ready
            && (req_word.req_type != spq_pkg::REQ_UPGRADE)
        |-> ##2 rsp_valid
    ) else $error("response word missing after request");

    // Stalled response holds
    a_rsp_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word)
    ) else $error("stalled response word changed");

    // Empty queue reports a zero front and a zero count
    a_empty_front: assert property (
        @(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_word.queue_empty
        |-> (rsp_word.front_id == '0) && (rsp_word.front_prio == '0)
            && (rsp_word.entry_count == '0)
    ) else $error("empty queue shows a front entry");

endmodule

bind sorted_priority_queue_with_upgrade_core spq_port_checks u_spq_port_checks (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_word  (req.payload),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_word  (rsp.payload)
);

// ----- test/spq_checker.sv -----
// Watches both channels, predicts every response word and compares it.
module spq_checker (
    input  logic          clk,
    input  logic          rst_n,
    spq_stream_if.monitor req,
    spq_stream_if.monitor rsp,
    output int            fail_count,
    output int            pending
);

    localparam int DEPTH      = 64;
    localparam int SHOW_LIMIT = 10;

    // Shadow copy of the sorted row, front at index 0
    logic [spq_pkg::ID_W-1:0]          row_ids [DEPTH];
    logic signed [spq_pkg::PRIO_W-1:0] row_prios [DEPTH];
    int                                row_len;
    spq_pkg::spq_rsp_t                 awaited_rsps [$];

    function automatic spq_pkg::spq_rsp_t apply_request(input spq_pkg::spq_req_t w);
        spq_pkg::spq_rsp_t                 r;
        logic signed [spq_pkg::PRIO_W-1:0] pr;
        int                                pos;
        int                                hit;
        r  = '0;
        pr = w.prio_value;
        r.status = spq_pkg::ST_OK;
        case (w.req_type)
            spq_pkg::REQ_INSERT:
            begin
                if (row_len >= DEPTH)
                    r.status = spq_pkg::ST_FULL;
                else
                begin
                    // goes behind every entry of equal or lower priority
                    pos = 0;
                    while (pos < row_len && row_prios[pos] <= pr)
                        pos++;
                    for (int i = row_len; i > pos; i--)
                    begin
                        row_ids[i]   = row_ids[i-1];
                        row_prios[i] = row_prios[i-1];
                    end
                    row_ids[pos]   = w.patient_id;
                    row_prios[pos] = pr;
                    row_len++;
                end
            end
            spq_pkg::REQ_POP:
            begin
                if (row_len == 0)
                    r.status = spq_pkg::ST_EMPTY;
                else
                begin
                    r.popped_id   = row_ids[0];
                    r.popped_prio = row_prios[0];
                    for (int i = 1; i < row_len; i++)
                    begin
                        row_ids[i-1]   = row_ids[i];
                        row_prios[i-1] = row_prios[i];
                    end
                    row_len--;
                end
            end
            spq_pkg::REQ_UPGRADE:
            begin
                hit = -1;
                for (int i = 0; i < row_len; i++)
                    if (hit < 0 && row_ids[i] == w.patient_id)
                        hit = i;
                if (hit < 0)
                    r.status = spq_pkg::ST_NOTFOUND;
                else if (row_prios[hit] < pr)
                    r.status = spq_pkg::ST_NOTURGENT;
                else
                begin
                    // equal priorities ahead of it stay ahead
                    pos = 0;
                    while (pos < hit && row_prios[pos] <= pr)
                        pos++;
                    for (int i = hit; i > pos; i--)
                    begin
                        row_ids[i]   = row_ids[i-1];
                        row_prios[i] = row_prios[i-1];
                    end
                    row_ids[pos]   = w.patient_id;
                    row_prios[pos] = pr;
                end
            end
            default:
                row_len = 0;
        endcase
        if (row_len > 0)
        begin
            r.front_id   = row_ids[0];
            r.front_prio = row_prios[0];
        end
        else
            r.queue_empty = 1'b1;
        r.entry_count = row_len[spq_pkg::CNT_OUT_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        spq_pkg::spq_rsp_t want;
        spq_pkg::spq_rsp_t got;
        if (!rst_n)
        begin
            row_len    = 0;
            fail_count = 0;
            pending    = 0;
            awaited_rsps.delete();
        end
        else
        begin
            // check the response side first so an early word is never hidden
            if (rsp.valid && rsp.ready)
            begin
                got = rsp.payload;
                if (awaited_rsps.size() == 0)
                begin
                    if (fail_count < SHOW_LIMIT)
                        $display("%0t: response word with none pending: %p", $realtime, got);
                    fail_count++;
                end
                else
                begin
                    want = awaited_rsps.pop_front();
                    if (got.status !== want.status || got.popped_id !== want.popped_id ||
                        got.popped_prio !== want.popped_prio ||
                        got.front_id !== want.front_id ||
                        got.front_prio !== want.front_prio ||
                        got.queue_empty !== want.queue_empty ||
                        got.entry_count !== want.entry_count)
                    begin
                        if (fail_count < SHOW_LIMIT)
                        begin
                            $display("%0t: response mismatch", $realtime);
                            $display("  expected %p", want);
                            $display("  actual   %p", got);
                        end
                        fail_count++;
                    end
                end
            end
            if (req.valid && req.ready)
                awaited_rsps.push_back(apply_request(req.payload));
            pending = awaited_rsps.size();
        end
    end

endmodule

// ----- test/testbench.sv -----
// Stimulus, handshake pacing and verdict for the sorted priority queue.
module testbench;

    localparam int STALL_LIMIT = 5000;
    localparam int FILL_BURST  = 66;
    localparam int MIXED_ITEMS = 70;
    localparam int REQ_W       = spq_pkg::REQ_W;
    localparam int ID_W        = spq_pkg::ID_W;
    localparam int PRIO_W      = spq_pkg::PRIO_W;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   quiet_cycles;
    logic req_taken;

    spq_stream_if #(.payload_t(spq_pkg::spq_req_t)) req_ch ();
    spq_stream_if #(.payload_t(spq_pkg::spq_rsp_t)) rsp_ch ();

    sorted_priority_queue_with_upgrade_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    spq_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // acceptance seen at the rising edge, read by the driver at the falling one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_taken <= 1'b0;
        else
            req_taken <= req_ch.valid && req_ch.ready;
    end

    always @(negedge clk)
        rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(input logic [REQ_W-1:0] op, input logic [ID_W-1:0] id,
                             input logic [PRIO_W-1:0] prio);
        spq_pkg::spq_req_t w;
        w.req_type   = op;
        w.patient_id = id;
        w.prio_value = prio;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid   = 1'b1;
        req_ch.payload = w;
        do
            @(negedge clk);
        while (!req_taken);
    endtask

    // small id pool so upgrades find their target most of the time
    function automatic logic [ID_W-1:0] pick_id();
        if ($urandom_range(0, 99) < 75)
            return ID_W'($urandom_range(0, 15));
        return ID_W'($urandom());
    endfunction

    // narrow band gives plenty of ties
    function automatic logic [PRIO_W-1:0] pick_prio();
        if ($urandom_range(0, 99) < 60)
            return PRIO_W'($urandom_range(0, 16) - 8);
        return PRIO_W'($urandom());
    endfunction

    task automatic send_random_word();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 35)
            send_word(spq_pkg::REQ_INSERT, pick_id(), pick_prio());
        else if (roll < 65)
            send_word(spq_pkg::REQ_POP, ID_W'($urandom()), PRIO_W'($urandom()));
        else if (roll < 95)
            send_word(spq_pkg::REQ_UPGRADE, pick_id(), pick_prio());
        else
            send_word(spq_pkg::REQ_CLEAR, ID_W'($urandom()), PRIO_W'($urandom()));
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        // fill past capacity so full inserts and upgrades on a full row show up
        repeat (FILL_BURST)
            send_word(spq_pkg::REQ_INSERT, pick_id(), pick_prio());
        repeat (MIXED_ITEMS)
            send_random_word();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        rsp_ch.ready   = 1'b0;
        quiet_cycles   = 0;
        send_idle_pct  = 21;
        recv_idle_pct  = 53;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed corners
        send_word(spq_pkg::REQ_POP, 16'h0000, 16'h0000);
        send_word(spq_pkg::REQ_UPGRADE, 16'h0005, 16'h0000);
        send_word(spq_pkg::REQ_INSERT, 16'h0000, 16'h7FFF);
        send_word(spq_pkg::REQ_INSERT, 16'hFFFF, 16'h8000);
        send_word(spq_pkg::REQ_INSERT, 16'h0005, 16'h0003);
        send_word(spq_pkg::REQ_INSERT, 16'h0006, 16'h0003);
        send_word(spq_pkg::REQ_INSERT, 16'h0007, 16'h0003);
        send_word(spq_pkg::REQ_UPGRADE, 16'h0007, 16'h0003);   // same priority keeps its place
        send_word(spq_pkg::REQ_UPGRADE, 16'h0007, 16'h0004);   // already more urgent
        send_word(spq_pkg::REQ_UPGRADE, 16'h0000, 16'h0003);   // lands behind the ties
        send_word(spq_pkg::REQ_UPGRADE, 16'h0006, 16'h0002);
        send_word(spq_pkg::REQ_UPGRADE, 16'h1234, 16'h0000);   // no match
        send_word(spq_pkg::REQ_INSERT, 16'h0005, 16'hFFFF);
        send_word(spq_pkg::REQ_UPGRADE, 16'h0005, 16'hFFFE);   // front-most duplicate moves
        send_word(spq_pkg::REQ_POP, 16'hFFFF, 16'hFFFF);
        send_word(spq_pkg::REQ_POP, 16'h0000, 16'h0000);
        send_word(spq_pkg::REQ_INSERT, 16'hAAAA, 16'h5555);
        send_word(spq_pkg::REQ_INSERT, 16'h5555, 16'hAAAA);
        send_word(spq_pkg::REQ_CLEAR, 16'h0000, 16'h0000);
        send_word(spq_pkg::REQ_POP, 16'h0000, 16'h0000);
        send_word(spq_pkg::REQ_UPGRADE, 16'hAAAA, 16'h0000);
        send_word(spq_pkg::REQ_INSERT, 16'h0009, 16'h7FFF);
        send_word(spq_pkg::REQ_UPGRADE, 16'h0009, 16'h8000);
        send_word(spq_pkg::REQ_CLEAR, 16'hFFFF, 16'hFFFF);

        run_phase(21, 53);
        run_phase(53, 21);
        run_phase(0, 0);
        req_ch.valid = 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/spq_pkg.sv
sv/spq_stream_if.sv
sv/spq_ctrl.sv
sv/spq_datapath.sv
sv/sorted_priority_queue_with_upgrade_core.sv
sv/spq_checker.sv
test/spq_checker.sv
test/testbench.sv
